>>> design/lcat_pkg.sv
// Shared constants, register index codes and configuration struct for the
// load-cell auto-tare filter. No dependencies.
`default_nettype none

package lcat_pkg;

  // Field widths
  localparam int unsigned SMP_W  = 24;  // sample and average
  localparam int unsigned CAL_W  = 25;  // average minus tare offset
  localparam int unsigned GRAM_W = 21;
  localparam int unsigned MLB_W  = 22;
  localparam int unsigned THR_W  = 24;
  localparam int unsigned LIM_W  = 16;
  localparam int unsigned SCL_W  = 20;
  localparam int unsigned FRAC_W = 16;  // Q16 scale factors

  // Configuration port
  localparam int unsigned CFG_DW = 24;
  localparam int unsigned CFG_AW = 3;

  // Default window length
  localparam int unsigned WINDOW_DEF = 8;

  // Reset values
  localparam logic [THR_W-1:0] STABLE_THR_RST = 24'd64;
  localparam logic [LIM_W-1:0] STABLE_LIM_RST = 16'd128;
  localparam logic [THR_W-1:0] RANGE_THR_RST  = 24'd256;
  localparam logic [LIM_W-1:0] RANGE_LIM_RST  = 16'd1024;
  localparam logic [SCL_W-1:0] GRAM_SCL_RST   = 20'd3052;
  localparam logic [SCL_W-1:0] MLB_SCL_RST    = 20'd6728;
  localparam logic [LIM_W-1:0] RANGE_CNT_RST  = 16'd1024;

  typedef enum logic [CFG_AW-1:0] {
    CFG_STABLE_THR = 3'd0,
    CFG_STABLE_LIM = 3'd1,
    CFG_RANGE_THR  = 3'd2,
    CFG_RANGE_LIM  = 3'd3,
    CFG_GRAM_SCL   = 3'd4,
    CFG_MLB_SCL    = 3'd5
  } lcat_cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0] stable_thr;
    logic [LIM_W-1:0] stable_lim;
    logic [THR_W-1:0] range_thr;
    logic [LIM_W-1:0] range_lim;
    logic [SCL_W-1:0] gram_scl;
    logic [SCL_W-1:0] mlb_scl;
  } lcat_cfg_t;

endpackage

`default_nettype wire

>>> design/lcat_ring.sv
// Input register, sample shift line and running window sum.
// Depends on lcat_pkg.
`default_nettype none

module lcat_ring
  import lcat_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF,
  localparam int unsigned SUM_W = SMP_W + $clog2(WINDOW)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         stall_o,
  input  wire logic signed [SMP_W-1:0] smp_i,
  output logic                         valid_o,
  input  wire logic                    stall_i,
  output logic signed [SUM_W-1:0]      sum_o
);

  logic                    va_q, vb_q;
  logic                    stall_a, stall_b, load_b;
  logic signed [SMP_W-1:0] smp_q;
  logic signed [SMP_W-1:0] ring_q [WINDOW];
  logic signed [SUM_W-1:0] sum_q, sum_d;

  assign stall_b = vb_q && stall_i;
  assign stall_a = va_q && stall_b;
  assign load_b  = va_q && !stall_b;
  assign stall_o = stall_a;

  // oldest sample leaves at the far end of the line
  assign sum_d = sum_q + SUM_W'(smp_q) - SUM_W'(ring_q[WINDOW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (!stall_a) begin
        va_q <= valid_i;
      end
      if (!stall_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_a) begin
      smp_q <= smp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (load_b) begin
      ring_q[0] <= smp_q;
      for (int i = 1; i < WINDOW; i++) begin
        ring_q[i] <= ring_q[i-1];
      end
      sum_q <= sum_d;
    end
  end

  assign valid_o = vb_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

>>> design/lcat_avg.sv
// Floor division of the window sum by WINDOW: a slice for powers of two,
// otherwise an exact reciprocal multiply. Depends on lcat_pkg.
`default_nettype none

module lcat_avg
  import lcat_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF,
  localparam int unsigned SUM_W = SMP_W + $clog2(WINDOW)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         stall_o,
  input  wire logic signed [SUM_W-1:0] sum_i,
  output logic                         valid_o,
  input  wire logic                    stall_i,
  output logic signed [SMP_W-1:0]      avg_o
);

  localparam int unsigned LOG_W = $clog2(WINDOW);
  localparam bit          IS_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

  logic v_q;
  logic load;

  assign stall_o = v_q && stall_i;
  assign load    = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall_o) begin
      v_q <= valid_i;
    end
  end

  generate
    if (IS_POW2) begin : g_shift
      logic signed [SMP_W-1:0] avg_q;

      always_ff @(posedge clk_i) begin
        if (load) begin
          avg_q <= sum_i[SUM_W-1:LOG_W];
        end
      end

      assign avg_o = avg_q;
    end else begin : g_recip
      // Bias makes the sum non-negative; quotient is then floor(sum/W) + 2^23,
      // so flipping the top bit removes the bias again.
      localparam int unsigned N      = SUM_W;
      localparam int unsigned PROD_W = 2 * N + 1;
      localparam logic [63:0] ONE    = 64'd1;
      localparam logic [63:0] BIAS_F = 64'(WINDOW) << (SMP_W - 1);
      localparam logic [63:0] RCP_F  =
        ((ONE << (N + LOG_W)) + 64'(WINDOW) - ONE) / 64'(WINDOW);
      localparam logic [N-1:0] BIAS  = BIAS_F[N-1:0];
      localparam logic [N:0]   RCP   = RCP_F[N:0];

      logic [N-1:0]      ubias;
      logic [PROD_W-1:0] prod_q;
      logic [SMP_W-1:0]  quo;

      assign ubias = $unsigned(sum_i) + BIAS;

      always_ff @(posedge clk_i) begin
        if (load) begin
          prod_q <= PROD_W'(ubias) * PROD_W'(RCP);
        end
      end

      assign quo   = prod_q[N+LOG_W+SMP_W-1:N+LOG_W];
      assign avg_o = $signed({~quo[SMP_W-1], quo[SMP_W-2:0]});
    end
  endgenerate

  assign valid_o = v_q;

endmodule

`default_nettype wire

>>> design/lcat_tare.sv
// Zero tracking: tare subtraction, stability and range counters, offset
// update. Depends on lcat_pkg.
`default_nettype none

module lcat_tare
  import lcat_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lcat_cfg_t               cfg_i,
  input  wire logic                    valid_i,
  output logic                         stall_o,
  input  wire logic signed [SMP_W-1:0] avg_i,
  output logic                         valid_o,
  input  wire logic                    stall_i,
  output logic signed [SMP_W-1:0]      avg_o,
  output logic signed [CAL_W-1:0]      cal_o,
  output logic                         stable_o,
  output logic                         tared_o
);

  function automatic logic [LIM_W-1:0] cnt_step(input logic [LIM_W-1:0] cnt,
                                                input logic             hit,
                                                input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] res;
    if (!hit) begin
      res = '0;
    end else if (cnt < lim) begin
      res = cnt + 1'b1;
    end else begin
      res = lim;
    end
    return res;
  endfunction

  logic                    v_q, load;
  logic signed [SMP_W-1:0] tare_q, prev_q;
  logic [LIM_W-1:0]        stab_cnt_q, rng_cnt_q;
  logic [LIM_W-1:0]        stab_nxt, rng_nxt;
  logic signed [CAL_W-1:0] cal, dif;
  logic [CAL_W-1:0]        cal_mag, dif_mag;
  logic                    rng_hit, stab_hit, stable_now, tared;

  logic signed [SMP_W-1:0] avg_q;
  logic signed [CAL_W-1:0] cal_q;
  logic                    stable_q, tared_q;

  assign stall_o = v_q && stall_i;
  assign load    = valid_i && !stall_o;

  assign cal     = CAL_W'(avg_i) - CAL_W'(tare_q);
  assign dif     = CAL_W'(avg_i) - CAL_W'(prev_q);
  assign cal_mag = cal[CAL_W-1] ? CAL_W'(-cal) : CAL_W'(cal);
  assign dif_mag = dif[CAL_W-1] ? CAL_W'(-dif) : CAL_W'(dif);

  assign rng_hit  = cal_mag > {1'b0, cfg_i.range_thr};
  assign stab_hit = dif_mag < {1'b0, cfg_i.stable_thr};

  assign rng_nxt    = cnt_step(rng_cnt_q, rng_hit, cfg_i.range_lim);
  assign stab_nxt   = cnt_step(stab_cnt_q, stab_hit, cfg_i.stable_lim);
  assign stable_now = (stab_nxt == cfg_i.stable_lim);
  assign tared      = stable_now && (rng_nxt == cfg_i.range_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q        <= 1'b0;
      tare_q     <= '0;
      prev_q     <= '0;
      stab_cnt_q <= '0;
      rng_cnt_q  <= RANGE_CNT_RST;
    end else begin
      if (!stall_o) begin
        v_q <= valid_i;
      end
      if (load) begin
        prev_q <= avg_i;
        if (tared) begin
          tare_q     <= avg_i;
          stab_cnt_q <= '0;
          rng_cnt_q  <= '0;
        end else begin
          stab_cnt_q <= stab_nxt;
          rng_cnt_q  <= rng_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      avg_q    <= avg_i;
      cal_q    <= cal;
      stable_q <= stable_now;
      tared_q  <= tared;
    end
  end

  assign valid_o  = v_q;
  assign avg_o    = avg_q;
  assign cal_o    = cal_q;
  assign stable_o = stable_q;
  assign tared_o  = tared_q;

  a_tare_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && tared) |=> (stab_cnt_q == '0 && rng_cnt_q == '0))
    else $error("counters not cleared after offset update");

  a_tare_takes_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && tared) |=> (tare_q == $past(avg_i)))
    else $error("offset not set to the average");

  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (prev_q == $past(avg_i)))
    else $error("previous average not updated");

endmodule

`default_nettype wire

>>> design/lcat_scale.sv
// Output stage: Q16 scaling to grams and milli-pounds with saturation,
// result register. Depends on lcat_pkg.
`default_nettype none

module lcat_scale
  import lcat_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lcat_cfg_t               cfg_i,
  input  wire logic                    valid_i,
  output logic                         stall_o,
  input  wire logic signed [SMP_W-1:0] avg_i,
  input  wire logic signed [CAL_W-1:0] cal_i,
  input  wire logic                    stable_i,
  input  wire logic                    tared_i,
  output logic                         valid_o,
  input  wire logic                    stall_i,
  output logic signed [SMP_W-1:0]      avg_o,
  output logic signed [CAL_W-1:0]      cal_o,
  output logic signed [GRAM_W-1:0]     grams_o,
  output logic signed [MLB_W-1:0]      mlb_o,
  output logic                         stable_o,
  output logic                         tared_o
);

  localparam int unsigned PROD_W = CAL_W + SCL_W + 1;
  localparam int unsigned SH_W   = PROD_W - FRAC_W;

  logic                     v_q, load;
  logic signed [PROD_W-1:0] prod_g, prod_m;
  logic signed [SH_W-1:0]   sh_g, sh_m;
  logic                     ovf_g, ovf_m;
  logic signed [GRAM_W-1:0] grams;
  logic signed [MLB_W-1:0]  mlb;

  logic signed [SMP_W-1:0]  avg_q;
  logic signed [CAL_W-1:0]  cal_q;
  logic signed [GRAM_W-1:0] grams_q;
  logic signed [MLB_W-1:0]  mlb_q;
  logic                     stable_q, tared_q;

  assign stall_o = v_q && stall_i;
  assign load    = valid_i && !stall_o;

  assign prod_g = PROD_W'(cal_i) * PROD_W'($signed({1'b0, cfg_i.gram_scl}));
  assign prod_m = PROD_W'(cal_i) * PROD_W'($signed({1'b0, cfg_i.mlb_scl}));

  // arithmetic shift: floor toward minus infinity
  assign sh_g = prod_g[PROD_W-1:FRAC_W];
  assign sh_m = prod_m[PROD_W-1:FRAC_W];

  assign ovf_g = !((&sh_g[SH_W-1:GRAM_W-1]) || !(|sh_g[SH_W-1:GRAM_W-1]));
  assign ovf_m = !((&sh_m[SH_W-1:MLB_W-1])  || !(|sh_m[SH_W-1:MLB_W-1]));

  always_comb begin
    if (!ovf_g) begin
      grams = sh_g[GRAM_W-1:0];
    end else if (sh_g[SH_W-1]) begin
      grams = $signed({1'b1, {(GRAM_W-1){1'b0}}});
    end else begin
      grams = $signed({1'b0, {(GRAM_W-1){1'b1}}});
    end
    if (!ovf_m) begin
      mlb = sh_m[MLB_W-1:0];
    end else if (sh_m[SH_W-1]) begin
      mlb = $signed({1'b1, {(MLB_W-1){1'b0}}});
    end else begin
      mlb = $signed({1'b0, {(MLB_W-1){1'b1}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      avg_q    <= avg_i;
      cal_q    <= cal_i;
      grams_q  <= grams;
      mlb_q    <= mlb;
      stable_q <= stable_i;
      tared_q  <= tared_i;
    end
  end

  assign valid_o  = v_q;
  assign avg_o    = avg_q;
  assign cal_o    = cal_q;
  assign grams_o  = grams_q;
  assign mlb_o    = mlb_q;
  assign stable_o = stable_q;
  assign tared_o  = tared_q;

endmodule

`default_nettype wire

>>> design/load_cell_auto_tare_filter_top.sv
// Top level of the load-cell auto-tare filter: configuration registers and
// the five-stage pipeline. Depends on lcat_pkg, lcat_ring, lcat_avg,
// lcat_tare and lcat_scale.
`default_nettype none

// Moving-average filter with automatic zero tracking for a 24-bit load-cell
// converter. Each input transaction carries one signed sample; each produces
// exactly one output transaction, in order. The block takes one transaction
// per clock while no stall holds it. The result passes through five
// registers on the way: input register, window sum, average, zero
// tracking, scaling/output register. The figure of one transaction per clock
// is set by the zero-tracking stage, whose offset and counters are updated
// every cycle a transaction passes; the window sum likewise loops through a
// single register. The window is a shift line of WINDOW samples cleared by
// reset, so no clearing pass is needed. A WINDOW that is a power of two
// divides by slicing; any other value uses an exact reciprocal multiply in
// the average stage. Stalls propagate stage by stage from out_stall_i, so
// empty stages still fill while a result waits. Configuration registers are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i and should only change
// while no transaction is in flight; unknown indexes are ignored.

module load_cell_auto_tare_filter_top
  import lcat_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_AW-1:0]        cfg_idx_i,
  input  wire logic [CFG_DW-1:0]        cfg_wdata_i,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [SMP_W-1:0]  in_raw_sample_i,
  // output channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [SMP_W-1:0]       out_average_value_o,
  output logic signed [CAL_W-1:0]       out_calibrated_value_o,
  output logic signed [GRAM_W-1:0]      out_weight_grams_o,
  output logic signed [MLB_W-1:0]       out_weight_millipounds_o,
  output logic                          out_is_stable_o,
  output logic                          out_tare_updated_o
);

  localparam int unsigned SUM_W = SMP_W + $clog2(WINDOW);

  lcat_cfg_t cfg_q;

  // stage interconnect
  logic                    sum_valid, sum_stall;
  logic signed [SUM_W-1:0] sum;
  logic                    avg_valid, avg_stall;
  logic signed [SMP_W-1:0] avg;
  logic                    trk_valid, trk_stall;
  logic signed [SMP_W-1:0] trk_avg;
  logic signed [CAL_W-1:0] trk_cal;
  logic                    trk_stable, trk_tared;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stable_thr <= STABLE_THR_RST;
      cfg_q.stable_lim <= STABLE_LIM_RST;
      cfg_q.range_thr  <= RANGE_THR_RST;
      cfg_q.range_lim  <= RANGE_LIM_RST;
      cfg_q.gram_scl   <= GRAM_SCL_RST;
      cfg_q.mlb_scl    <= MLB_SCL_RST;
    end else if (cfg_we_i) begin
      unique case (lcat_cfg_idx_e'(cfg_idx_i))
        CFG_STABLE_THR: cfg_q.stable_thr <= cfg_wdata_i[THR_W-1:0];
        CFG_STABLE_LIM: cfg_q.stable_lim <= cfg_wdata_i[LIM_W-1:0];
        CFG_RANGE_THR:  cfg_q.range_thr  <= cfg_wdata_i[THR_W-1:0];
        CFG_RANGE_LIM:  cfg_q.range_lim  <= cfg_wdata_i[LIM_W-1:0];
        CFG_GRAM_SCL:   cfg_q.gram_scl   <= cfg_wdata_i[SCL_W-1:0];
        CFG_MLB_SCL:    cfg_q.mlb_scl    <= cfg_wdata_i[SCL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register + window sum (two stages)
  lcat_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .smp_i   (in_raw_sample_i),
    .valid_o (sum_valid),
    .stall_i (sum_stall),
    .sum_o   (sum)
  );

  // Floor average
  lcat_avg #(
    .WINDOW (WINDOW)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .stall_o (sum_stall),
    .sum_i   (sum),
    .valid_o (avg_valid),
    .stall_i (avg_stall),
    .avg_o   (avg)
  );

  // Zero tracking; holds offset, previous average and both counters
  lcat_tare u_tare (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (avg_valid),
    .stall_o  (avg_stall),
    .avg_i    (avg),
    .valid_o  (trk_valid),
    .stall_i  (trk_stall),
    .avg_o    (trk_avg),
    .cal_o    (trk_cal),
    .stable_o (trk_stable),
    .tared_o  (trk_tared)
  );

  // Unit scaling and result register
  lcat_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (trk_valid),
    .stall_o  (trk_stall),
    .avg_i    (trk_avg),
    .cal_i    (trk_cal),
    .stable_i (trk_stable),
    .tared_i  (trk_tared),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .avg_o    (out_average_value_o),
    .cal_o    (out_calibrated_value_o),
    .grams_o  (out_weight_grams_o),
    .mlb_o    (out_weight_millipounds_o),
    .stable_o (out_is_stable_o),
    .tared_o  (out_tare_updated_o)
  );

  // A tare update is only possible on a stable transaction
  a_tare_needs_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_tare_updated_o) |-> out_is_stable_o)
    else $error("tare update without stability");

  // Back-pressure only ever originates at the output register
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with output free");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CFG_STABLE_LIM)
      |=> (cfg_q.stable_lim == $past(cfg_wdata_i[LIM_W-1:0])))
    else $error("stable limit write lost");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the load-cell auto-tare filter: a scoreboard class
// predicts the average, tare and weight readings; plain tasks drive the block.
// Depends on lcat_pkg and load_cell_auto_tare_filter_top.

module testbench
  import lcat_pkg::*;
;

  localparam int unsigned STALL_LIMIT = 3000;   // cycles without any transaction
  localparam int unsigned HOLD_CYCLES = 90;     // long output hold-off
  localparam int unsigned HOLD_AT     = 500;    // input count that triggers it
  localparam logic [CFG_AW-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_SPARE_7 = 3'd7;
  localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 24'sh800000;
  localparam logic [THR_W-1:0] THR_ALL = '1;
  localparam logic [SCL_W-1:0] SCL_ALL = '1;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  typedef struct {
    logic signed [SMP_W-1:0]  average;
    logic signed [CAL_W-1:0]  calibrated;
    logic signed [GRAM_W-1:0] grams;
    logic signed [MLB_W-1:0]  millipounds;
    logic                     stable;
    logic                     tared;
  } reading_t;

  class weighing_scoreboard;
    localparam longint WIN      = WINDOW_DEF;
    localparam longint GRAM_MAX = (64'sd1 <<< (GRAM_W - 1)) - 1;
    localparam longint MLB_MAX  = (64'sd1 <<< (MLB_W - 1)) - 1;

    lcat_cfg_t               regs;
    logic signed [SMP_W-1:0] ring [WINDOW_DEF];
    longint                  window_sum;
    int                      slot;
    logic signed [SMP_W-1:0] tare;
    logic signed [SMP_W-1:0] prev_avg;
    int unsigned             stable_cnt;
    int unsigned             range_cnt;
    reading_t                expected_readings[$];
    int unsigned             mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      window_sum = 0;
      slot       = 0;
      tare       = '0;
      prev_avg   = '0;
      stable_cnt = 0;
      range_cnt  = RANGE_CNT_RST;
      regs       = '{STABLE_THR_RST, STABLE_LIM_RST, RANGE_THR_RST, RANGE_LIM_RST,
                     GRAM_SCL_RST, MLB_SCL_RST};
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_STABLE_THR: regs.stable_thr = data[THR_W-1:0];
        CFG_STABLE_LIM: regs.stable_lim = data[LIM_W-1:0];
        CFG_RANGE_THR:  regs.range_thr  = data[THR_W-1:0];
        CFG_RANGE_LIM:  regs.range_lim  = data[LIM_W-1:0];
        CFG_GRAM_SCL:   regs.gram_scl   = data[SCL_W-1:0];
        CFG_MLB_SCL:    regs.mlb_scl    = data[SCL_W-1:0];
        default: ;  // spare index, ignored
      endcase
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint clip(longint v, longint hi);
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // saturating count; a lowered limit clamps, a failed condition clears
    function int unsigned bump(int unsigned cnt, bit hit, int unsigned lim);
      if (!hit) return 0;
      if (cnt < lim) return cnt + 1;
      return lim;
    endfunction

    function reading_t predict_reading(logic signed [SMP_W-1:0] s);
      reading_t r;
      longint   avg;
      longint   cal;
      longint   g;
      longint   m;
      bit       stable_now;
      window_sum = window_sum + longint'(s) - longint'(ring[slot]);
      ring[slot] = s;
      slot       = (slot + 1) % WINDOW_DEF;
      avg = window_sum / WIN;
      if ((window_sum % WIN) != 0 && window_sum < 0) avg--;
      cal = avg - longint'(tare);
      g   = clip((cal * longint'(regs.gram_scl)) >>> FRAC_W, GRAM_MAX);
      m   = clip((cal * longint'(regs.mlb_scl)) >>> FRAC_W, MLB_MAX);
      range_cnt  = bump(range_cnt, magnitude(cal) > longint'(regs.range_thr),
                        regs.range_lim);
      stable_cnt = bump(stable_cnt,
                        magnitude(avg - longint'(prev_avg)) < longint'(regs.stable_thr),
                        regs.stable_lim);
      stable_now = (stable_cnt == regs.stable_lim);
      r.tared = 1'b0;
      if (stable_now && range_cnt == regs.range_lim) begin
        tare       = avg[SMP_W-1:0];
        range_cnt  = 0;
        stable_cnt = 0;
        r.tared    = 1'b1;
      end
      prev_avg      = avg[SMP_W-1:0];
      r.average     = avg[SMP_W-1:0];
      r.calibrated  = cal[CAL_W-1:0];
      r.grams       = g[GRAM_W-1:0];
      r.millipounds = m[MLB_W-1:0];
      r.stable      = stable_now;
      return r;
    endfunction

    function void note_sample(logic signed [SMP_W-1:0] s);
      expected_readings.push_back(predict_reading(s));
    endfunction

    function void check_reading(reading_t got);
      reading_t exp_r;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reading with no sample outstanding: avg %0d cal %0d",
                   $realtime, got.average, got.calibrated);
        return;
      end
      exp_r = expected_readings.pop_front();
      if (got.average !== exp_r.average || got.calibrated !== exp_r.calibrated ||
          got.grams !== exp_r.grams || got.millipounds !== exp_r.millipounds ||
          got.stable !== exp_r.stable || got.tared !== exp_r.tared) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: reading mismatch", $realtime);
          $display("  exp avg %0d cal %0d g %0d mlb %0d stable %0b tare %0b",
                   exp_r.average, exp_r.calibrated, exp_r.grams, exp_r.millipounds,
                   exp_r.stable, exp_r.tared);
          $display("  got avg %0d cal %0d g %0d mlb %0d stable %0b tare %0b",
                   got.average, got.calibrated, got.grams, got.millipounds,
                   got.stable, got.tared);
        end
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_AW-1:0]         cfg_idx_i;
  logic [CFG_DW-1:0]         cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [SMP_W-1:0]   in_raw_sample_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [SMP_W-1:0]   out_average_value_o;
  logic signed [CAL_W-1:0]   out_calibrated_value_o;
  logic signed [GRAM_W-1:0]  out_weight_grams_o;
  logic signed [MLB_W-1:0]   out_weight_millipounds_o;
  logic                      out_is_stable_o;
  logic                      out_tare_updated_o;

  weighing_scoreboard board;
  int unsigned        samples_seen;

  load_cell_auto_tare_filter_top u_top (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_idx_i                (cfg_idx_i),
    .cfg_wdata_i              (cfg_wdata_i),
    .in_valid_i               (in_valid_i),
    .in_stall_o               (in_stall_o),
    .in_raw_sample_i          (in_raw_sample_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .out_average_value_o      (out_average_value_o),
    .out_calibrated_value_o   (out_calibrated_value_o),
    .out_weight_grams_o       (out_weight_grams_o),
    .out_weight_millipounds_o (out_weight_millipounds_o),
    .out_is_stable_o          (out_is_stable_o),
    .out_tare_updated_o       (out_tare_updated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Monitor: result checked before the same edge's sample is noted
  always @(posedge clk_i) begin : monitor
    reading_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.average     = out_average_value_o;
        got.calibrated  = out_calibrated_value_o;
        got.grams       = out_weight_grams_o;
        got.millipounds = out_weight_millipounds_o;
        got.stable      = out_is_stable_o;
        got.tared       = out_tare_updated_o;
        board.check_reading(got);
      end
      if (in_valid_i && !in_stall_o) begin
        board.note_sample(in_raw_sample_i);
        samples_seen++;
      end
    end
  end

  // Receiver: stall modes change every so often; one long hold-off mid-run
  initial begin : receiver
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned tick;
    out_stall_i = 1'b0;
    mode        = STALL_NONE;
    mode_left   = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    tick        = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (!hold_done && samples_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 99) < 25);
          STALL_PERIODIC: out_stall_i <= ((tick % 3) == 0);
          default:        out_stall_i <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_sample(input logic signed [SMP_W-1:0] s);
    in_valid_i      <= 1'b1;
    in_raw_sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause(input int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // wait for every reading, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.expected_readings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [THR_W-1:0] st_thr, input logic [LIM_W-1:0] st_lim,
                               input logic [THR_W-1:0] rg_thr, input logic [LIM_W-1:0] rg_lim,
                               input logic [SCL_W-1:0] g_scl, input logic [SCL_W-1:0] m_scl);
    write_reg(CFG_STABLE_THR, CFG_DW'(st_thr));
    write_reg(CFG_STABLE_LIM, CFG_DW'(st_lim));
    write_reg(CFG_RANGE_THR,  CFG_DW'(rg_thr));
    write_reg(CFG_RANGE_LIM,  CFG_DW'(rg_lim));
    write_reg(CFG_GRAM_SCL,   CFG_DW'(g_scl));
    write_reg(CFG_MLB_SCL,    CFG_DW'(m_scl));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [SMP_W-1:0] to_sample(longint v);
    if (v > longint'(SMP_MAX)) return SMP_MAX;
    if (v < longint'(SMP_MIN)) return SMP_MIN;
    return v[SMP_W-1:0];
  endfunction

  // Runs of near-constant weight with random level and noise, some stray
  // full-range samples; the sender works in bursts with random gaps.
  task automatic run_samples(input int unsigned n, input int unsigned max_run,
                             input int unsigned noise_bits);
    int unsigned             run_left;
    int unsigned             burst_left;
    int                      amp;
    longint                  level;
    logic signed [SMP_W-1:0] s;
    run_left   = 0;
    burst_left = 0;
    level      = 0;
    amp        = 0;
    repeat (n) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, max_run);
        s        = SMP_W'($urandom);
        level    = $urandom_range(0, 1) ? longint'(s) : longint'($urandom_range(0, 8191)) - 4096;
        amp      = (1 << $urandom_range(0, noise_bits)) - 1;
      end
      run_left--;
      if ($urandom_range(0, 9) == 0) s = SMP_W'($urandom);
      else s = to_sample(level + longint'(int'($urandom_range(0, 2 * amp)) - amp));
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 30);
        pause($urandom_range(0, 12));
      end
      burst_left--;
      push_sample(s);
    end
    drain();
  endtask

  task automatic random_phase(input int unsigned n);
    logic [THR_W-1:0] st_thr;
    logic [THR_W-1:0] rg_thr;
    logic [LIM_W-1:0] st_lim;
    logic [LIM_W-1:0] rg_lim;
    st_thr = ($urandom_range(0, 7) == 0) ? THR_W'($urandom) : THR_W'($urandom_range(0, 600));
    rg_thr = ($urandom_range(0, 7) == 0) ? THR_W'($urandom) : THR_W'($urandom_range(0, 3000));
    st_lim = ($urandom_range(0, 9) == 0) ? LIM_W'($urandom) : LIM_W'($urandom_range(0, 12));
    rg_lim = ($urandom_range(0, 9) == 0) ? LIM_W'($urandom) : LIM_W'($urandom_range(0, 12));
    apply_setting(st_thr, st_lim, rg_thr, rg_lim, SCL_W'($urandom), SCL_W'($urandom));
    run_samples(n, $urandom_range(8, 60), $urandom_range(0, 10));
  endtask

  initial begin : stimulus
    board           = new();
    samples_seen    = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    in_raw_sample_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes with reset settings
    push_sample('0);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    drain();
    // tare follows the average whenever it moves off the offset, ending at the negative extreme
    apply_setting(THR_ALL, 16'd1, '0, 16'd1, SCL_ALL, SCL_ALL);
    repeat (8) push_sample(SMP_MIN);
    drain();
    // tracking off: full positive swing against that offset, weights saturate
    write_reg(CFG_RANGE_THR, CFG_DW'(THR_ALL));
    cfg_we_i <= 1'b0;
    repeat (8) push_sample(SMP_MAX);
    drain();
    // retare at the positive extreme, then the full negative swing
    write_reg(CFG_RANGE_THR, '0);
    cfg_we_i <= 1'b0;
    push_sample(SMP_MAX);
    drain();
    write_reg(CFG_RANGE_THR, CFG_DW'(THR_ALL));
    cfg_we_i <= 1'b0;
    repeat (8) push_sample(SMP_MIN);
    drain();

    // reset settings, long runs
    apply_setting(STABLE_THR_RST, STABLE_LIM_RST, RANGE_THR_RST, RANGE_LIM_RST,
                  GRAM_SCL_RST, MLB_SCL_RST);
    run_samples(250, 200, 4);
    // short limits and full-scale weights: frequent tare, saturation both ways
    apply_setting(24'd32, 16'd4, 24'd100, 16'd3, SCL_ALL, SCL_ALL);
    run_samples(250, 30, 5);
    // never stable, never out of range; limits written with spare high bits
    apply_setting('0, 16'hFFFF, THR_ALL, 16'hFFFF, 20'd65536, 20'd1);
    @(posedge clk_i);
    write_reg(CFG_STABLE_LIM, {8'hA5, 16'hFFFF});
    write_reg(CFG_RANGE_LIM,  {8'h5A, 16'hFFFF});
    write_reg(CFG_GRAM_SCL,   {4'hF, 20'h0ABCD});
    write_reg(CFG_SPARE_6,    '1);
    write_reg(CFG_SPARE_7,    '0);
    cfg_we_i <= 1'b0;
    run_samples(150, 40, 8);
    // zero limits: both counters always full, zero scales
    apply_setting(THR_ALL, '0, '0, '0, '0, '0);
    run_samples(150, 20, 6);
    // unit limits, unity gram scale
    apply_setting(24'd500, 16'd1, 24'd1000, 16'd1, 20'd65536, 20'd144470);
    run_samples(200, 25, 9);
    repeat (4) random_phase(200);

    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
